### design/bhrs_pkg.sv
// Shared types, constants and helper functions for the byte histogram rank sort unit.
// Every other design file imports this package; it depends on nothing.
`default_nettype none

package bhrs_pkg;

  // Alphabet size and counter width.
  localparam int SYMBOLS     = 256;
  localparam int COUNT_WIDTH = 32;

  // Derived widths and sequencing lengths.
  localparam int SYM_W        = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int KEY_W        = COUNT_WIDTH + SYM_W;
  localparam int DRAIN_CYCLES = SYMBOLS + 2;
  localparam int IDX_W        = $clog2(DRAIN_CYCLES + 1);
  localparam int FREQ_W       = 32;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_SORT  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SYM_W-1:0]       sym_t;
  typedef logic [KEY_W-1:0]       key_t;

  // Input word and result word.
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
    logic [7:0] rank_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        symbol;
    logic [FREQ_W-1:0] frequency;
  } out_word_t;

  // Request to the count store: one read, optionally followed by an increment.
  typedef struct packed {
    logic rd_en;
    logic inc;
    sym_t rd_addr;
  } cstore_req_t;

  // Mode control broadcast to every cell of the sorting chain.
  typedef struct packed {
    logic clear;
    logic shift;
  } chain_ctrl_t;

  // Saturating increment of one count.
  function automatic count_t sat_inc(input count_t c);
    if (c == '1) begin
      return c;
    end
    return count_t'(c + 1'b1);
  endfunction

  // Reported frequency: counts wider than the result field clamp at its maximum.
  function automatic logic [FREQ_W-1:0] freq_clamp(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    if (w > 64'(32'hFFFF_FFFF)) begin
      return '1;
    end
    return w[FREQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

### design/byte_histogram_rank_sort_unit.sv
// Byte histogram with rank sort. Count words are taken one per cycle with no result
// while the input is ready. A read word reads the rank table, then the count store;
// input waits until its result word is loaded. A sort word keeps the input busy for a
// count memory scan into the cell chain, a drain while the last keys settle, and a shift-out
// into the rank table. Synchronous reset clears all counts at once through per-symbol valid bits.
`default_nettype none

module byte_histogram_rank_sort_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  bhrs_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output bhrs_pkg::out_word_t  out_data
);
  import bhrs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RD_SYM = 6'b000010,
    S_RD_OUT = 6'b000100,
    S_FILL   = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_DUMP   = 6'b100000
  } state_t;

  state_t      state_r;
  state_t      state_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic        in_acc;
  op_t         op;
  logic        byte_ok;
  logic        rank_oob;
  cstore_req_t creq;
  count_t      cnt_data;
  chain_ctrl_t cctrl;
  key_t        head_key;
  logic        feed_v_r;
  sym_t        feed_sym_r;
  sym_t        rank_mem [SYMBOLS];
  sym_t        rank_q_r;
  logic        oob_r;
  logic        out_free;
  logic        load;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_word_t   out_data_r;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign op       = op_t'(in_data.operation);
  assign byte_ok  = ({1'b0, in_data.byte_value} < 9'(SYMBOLS));
  assign rank_oob = ({1'b0, in_data.rank_index} >= 9'(SYMBOLS));
  assign out_free = !out_valid_r || out_ready;
  assign load     = (state_r == S_RD_OUT) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Count store read port: counting, sort scan and the frequency lookup of a read.
  always_comb begin
    creq = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (op == OP_COUNT) && byte_ok) begin
          creq.rd_en   = 1'b1;
          creq.inc     = 1'b1;
          creq.rd_addr = in_data.byte_value[SYM_W-1:0];
        end
      end
      S_FILL: begin
        creq.rd_en   = 1'b1;
        creq.rd_addr = idx_r[SYM_W-1:0];
      end
      S_RD_SYM: begin
        creq.rd_en   = 1'b1;
        creq.rd_addr = rank_q_r;
      end
      default: begin
        creq = '0;
      end
    endcase
  end

  // Sequencer for sort and read words.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (op == OP_SORT)) begin
          state_nxt = S_FILL;
          idx_nxt   = '0;
        end else if (in_acc && (op == OP_READ)) begin
          state_nxt = S_RD_SYM;
        end
      end
      S_RD_SYM: begin
        state_nxt = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        if (idx_r == IDX_W'(SYMBOLS - 1)) begin
          state_nxt = S_DRAIN;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (idx_r == IDX_W'(DRAIN_CYCLES - 1)) begin
          state_nxt = S_DUMP;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DUMP: begin
        if (idx_r == IDX_W'(SYMBOLS - 1)) begin
          state_nxt = S_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  // Output register holds one result word until it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      feed_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      feed_v_r    <= (state_r == S_FILL);
      out_valid_r <= out_valid_nxt;
    end
  end

  // Symbol of the scanned count, aligned with the registered count data.
  always_ff @(posedge clk) begin
    feed_sym_r <= idx_r[SYM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (oob_r) begin
        out_data_r <= '0;
      end else begin
        out_data_r.symbol    <= 8'(rank_q_r);
        out_data_r.frequency <= freq_clamp(cnt_data);
      end
    end
  end

  // Rank table: filled from the chain head during the shift-out, read by a read word.
  always_ff @(posedge clk) begin
    if (state_r == S_DUMP) begin
      rank_mem[idx_r[SYM_W-1:0]] <= head_key[SYM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (op == OP_READ)) begin
      rank_q_r <= rank_mem[in_data.rank_index[SYM_W-1:0]];
      oob_r    <= rank_oob;
    end
  end

  assign cctrl.clear = in_acc && (op == OP_SORT);
  assign cctrl.shift = (state_r == S_DUMP);

  bhrs_count_store u_count_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (creq),
    .rd_data (cnt_data)
  );

  bhrs_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (cctrl),
    .feed_v   (feed_v_r),
    .feed_key ({cnt_data, feed_sym_r}),
    .head_key (head_key)
  );

endmodule

`default_nettype wire

### design/bhrs_count_store.sv
// Frequency memory with per-entry valid bits, registered read and saturating update.
// Depends on bhrs_pkg for widths, the request struct and sat_inc.
`default_nettype none

module bhrs_count_store (
  input  wire                  clk,
  input  wire                  rst_n,
  input  bhrs_pkg::cstore_req_t req,
  output bhrs_pkg::count_t     rd_data
);
  import bhrs_pkg::*;

  count_t               mem [SYMBOLS];
  logic [SYMBOLS-1:0]   vld_r;
  logic [SYMBOLS-1:0]   vld_nxt;
  count_t               rdata_r;
  logic                 vld_q_r;
  sym_t                 addr_r;
  logic                 inc_r;
  logic                 inc_nxt;
  logic                 fwd_r;
  logic                 fwd_nxt;
  count_t               fwd_data_r;
  sym_t                 fwd_addr_r;
  count_t               wr_data;

  // A write that lands on the same edge as a read sample is forwarded.
  assign rd_data = (fwd_r && (fwd_addr_r == addr_r)) ? fwd_data_r
                 : (vld_q_r ? rdata_r : '0);
  assign wr_data = sat_inc(rd_data);

  always_comb begin
    inc_nxt = req.rd_en & req.inc;
    fwd_nxt = inc_r;
    vld_nxt = vld_r;
    if (inc_r) begin
      vld_nxt[addr_r] = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      inc_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      inc_r <= inc_nxt;
      fwd_r <= fwd_nxt;
    end
  end

  // Memory write port and forwarding copy of the last write.
  always_ff @(posedge clk) begin
    if (inc_r) begin
      mem[addr_r] <= wr_data;
      fwd_data_r  <= wr_data;
      fwd_addr_r  <= addr_r;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
      vld_q_r <= vld_r[req.rd_addr];
      addr_r  <= req.rd_addr;
    end
  end

endmodule

`default_nettype wire

### design/bhrs_cell.sv
// One cell of the systolic insertion sorter: holds one key and passes the larger one on.
// Depends on bhrs_pkg for the key type and the chain control struct.
`default_nettype none

module bhrs_cell (
  input  wire                   clk,
  input  wire                   rst_n,
  input  bhrs_pkg::chain_ctrl_t ctrl,
  input  wire                   in_v,
  input  bhrs_pkg::key_t        in_key,
  input  bhrs_pkg::key_t        nbr_key,
  output logic                  out_v,
  output bhrs_pkg::key_t        out_key,
  output bhrs_pkg::key_t        held_key
);
  import bhrs_pkg::*;

  logic hv_r;
  logic hv_nxt;
  key_t h_r;
  key_t h_nxt;
  logic ov_r;
  logic ov_nxt;
  key_t ok_r;
  key_t ok_nxt;

  assign out_v    = ov_r;
  assign out_key  = ok_r;
  assign held_key = h_r;

  // Keep the smaller key, hand the larger one to the next cell; shift toward the head.
  always_comb begin
    hv_nxt = hv_r;
    h_nxt  = h_r;
    ov_nxt = 1'b0;
    ok_nxt = ok_r;
    if (ctrl.clear) begin
      hv_nxt = 1'b0;
    end else if (ctrl.shift) begin
      h_nxt = nbr_key;
    end else if (in_v) begin
      if (!hv_r) begin
        hv_nxt = 1'b1;
        h_nxt  = in_key;
      end else if (in_key < h_r) begin
        h_nxt  = in_key;
        ok_nxt = h_r;
        ov_nxt = 1'b1;
      end else begin
        ok_nxt = in_key;
        ov_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r  <= h_nxt;
    ok_r <= ok_nxt;
  end

endmodule

`default_nettype wire

### design/bhrs_chain.sv
// Row of sorting cells, one per symbol; keys enter at the head and settle in rank order.
// Depends on bhrs_pkg and bhrs_cell.
`default_nettype none

module bhrs_chain (
  input  wire                   clk,
  input  wire                   rst_n,
  input  bhrs_pkg::chain_ctrl_t ctrl,
  input  wire                   feed_v,
  input  bhrs_pkg::key_t        feed_key,
  output bhrs_pkg::key_t        head_key
);
  import bhrs_pkg::*;

  logic [SYMBOLS:0] v_link;
  key_t             k_link [SYMBOLS+1];
  key_t             held   [SYMBOLS+1];

  assign v_link[0] = feed_v;
  assign k_link[0] = feed_key;
  assign held[SYMBOLS] = '0;
  assign head_key = held[0];

  // Cell i takes new keys from cell i-1 and, when shifting, the held key of cell i+1.
  for (genvar i = 0; i < SYMBOLS; i++) begin : g_cell
    bhrs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .in_v     (v_link[i]),
      .in_key   (k_link[i]),
      .nbr_key  (held[i+1]),
      .out_v    (v_link[i+1]),
      .out_key  (k_link[i+1]),
      .held_key (held[i])
    );
  end

endmodule

`default_nettype wire
